>>> rtl/bhpa_pkg.sv
`default_nettype none

package bhpa_pkg;

    // Field widths
    localparam int ACTION_W    = 2;
    localparam int COUNT_W     = 6;
    localparam int HANDLE_W    = 5;
    localparam int STATUS_W    = 3;
    localparam int FREE_W      = 6;
    localparam int POOL_SIZE_W = 6;

    // Largest batch a single request may be granted
    localparam int MAX_RESULTS = 32;

    // pool_size register after reset
    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 6'd32;

    // Command queue depth between front and back
    localparam int FIFO_DEPTH = 2;

    // Action codes on the command channel
    localparam logic [ACTION_W-1:0] ACT_INIT    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

    // Status codes on the response channel
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    // Decoded command kinds
    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_REQUEST,
        KIND_RELEASE
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [COUNT_W-1:0]   count;
        logic [HANDLE_W-1:0]  handle;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/bhpa_cmd_if.sv
`default_nettype none

interface bhpa_cmd_if import bhpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [COUNT_W-1:0]  count;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output action, output count, output handle, input ready);
    modport sink   (input valid, input action, input count, input handle, output ready);
endinterface

`default_nettype wire

>>> rtl/bhpa_rsp_if.sv
`default_nettype none

interface bhpa_rsp_if import bhpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [FREE_W-1:0]   free_left;
    logic                last;

    modport source (output valid, output status, output granted_handle, output free_left,
                    output last, input ready);
    modport sink   (input valid, input status, input granted_handle, input free_left,
                    input last, output ready);
endinterface

`default_nettype wire

>>> rtl/bhpa_ram.sv
`default_nettype none

module bhpa_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bhpa_front.sv
`default_nettype none

module bhpa_front import bhpa_pkg::*; (
    bhpa_cmd_if.sink   cmd,
    output logic       push_valid,
    output cmd_t       push_cmd,
    input  wire logic  push_ready
);

    // Decode the action; unknown actions are accepted and dropped
    always_comb
    begin
        push_cmd.count  = cmd.count;
        push_cmd.handle = cmd.handle;
        push_cmd.kind   = KIND_INIT;
        push_valid      = 1'b0;
        case (cmd.action)
            ACT_INIT:
            begin
                push_cmd.kind = KIND_INIT;
                push_valid    = cmd.valid;
            end
            ACT_REQUEST:
            begin
                push_cmd.kind = KIND_REQUEST;
                push_valid    = cmd.valid;
            end
            ACT_RELEASE:
            begin
                push_cmd.kind = KIND_RELEASE;
                push_valid    = cmd.valid;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

    assign cmd.ready = push_ready;

endmodule

`default_nettype wire

>>> rtl/bhpa_cmd_fifo.sv
`default_nettype none

module bhpa_cmd_fifo import bhpa_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    output logic      pop_valid,
    output cmd_t      pop_cmd,
    input  wire logic pop
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bhpa_back.sv
`default_nettype none

module bhpa_back import bhpa_pkg::*; #(
    parameter int POOL_MAX = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [POOL_SIZE_W-1:0] cfg_wdata,
    input  wire logic                   q_valid,
    input  wire cmd_t                   q_cmd,
    output logic                        q_pop,
    bhpa_rsp_if.source                  rsp
);

    localparam int IDX_W  = $clog2(POOL_MAX);
    localparam int CNT_W  = $clog2(POOL_MAX + 1);
    localparam int FC_RST = (32'(POOL_SIZE_RST) > POOL_MAX) ? POOL_MAX : 32'(POOL_SIZE_RST);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_GRANT
    } state_t;

    state_t                  state_reg, state_next;
    logic [POOL_SIZE_W-1:0]  pool_size_reg, pool_size_next;
    logic [CNT_W-1:0]        fc_reg, fc_next;
    logic [POOL_MAX-1:0]     in_use_reg, in_use_next;
    logic [POOL_MAX-1:0]     written_reg, written_next;
    logic [COUNT_W-1:0]      rem_reg, rem_next;
    logic                    rd_written_reg, rd_written_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [HANDLE_W-1:0]     out_handle_reg, out_handle_next;
    logic [FREE_W-1:0]       out_free_reg, out_free_next;
    logic                    out_last_reg, out_last_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [IDX_W-1:0]        ram_rdata;

    logic                    out_room;
    logic [CNT_W-1:0]        eff_size;
    logic [IDX_W-1:0]        rel_idx;
    logic                    rel_ok;
    logic                    req_refuse;
    logic [IDX_W-1:0]        pop_handle;

    // Free stack storage
    bhpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_MAX)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Classification helpers
    assign out_room   = !out_valid_reg || rsp.ready;
    assign eff_size   = (32'(pool_size_reg) > POOL_MAX) ? CNT_W'(POOL_MAX)
                                                        : CNT_W'(pool_size_reg);
    assign rel_idx    = IDX_W'(q_cmd.handle);
    assign rel_ok     = (32'(q_cmd.handle) < POOL_MAX) && in_use_reg[rel_idx]
                        && (32'(fc_reg) < POOL_MAX);
    assign req_refuse = (32'(q_cmd.count) > 32'(fc_reg)) || (32'(q_cmd.count) > MAX_RESULTS);
    // Stack entries never written since init hold their own index
    assign pop_handle = rd_written_reg ? ram_rdata : rd_idx_reg;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        pool_size_next  = cfg_we ? cfg_wdata : pool_size_reg;
        fc_next         = fc_reg;
        in_use_next     = in_use_reg;
        written_next    = written_reg;
        rem_next        = rem_reg;
        rd_written_next = rd_written_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_free_next   = out_free_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = IDX_W'(fc_reg);
        ram_wdata       = rel_idx;
        ram_re          = 1'b0;
        ram_raddr       = IDX_W'(fc_reg - 1'b1);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        KIND_INIT:
                        begin
                            q_pop        = 1'b1;
                            in_use_next  = '0;
                            written_next = '0;
                            fc_next      = eff_size;
                        end
                        KIND_REQUEST:
                        begin
                            if (out_room)
                            begin
                                q_pop = 1'b1;
                                if (q_cmd.count == '0)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = ST_NONE;
                                    out_handle_next = '0;
                                    out_free_next   = FREE_W'(fc_reg);
                                    out_last_next   = 1'b1;
                                end
                                else if (req_refuse)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = ST_REFUSED;
                                    out_handle_next = '0;
                                    out_free_next   = FREE_W'(fc_reg);
                                    out_last_next   = 1'b1;
                                end
                                else
                                begin
                                    rem_next   = q_cmd.count;
                                    state_next = S_READ;
                                end
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (out_room)
                            begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_handle_next = '0;
                                out_last_next   = 1'b1;
                                if (rel_ok)
                                begin
                                    ram_we                         = 1'b1;
                                    in_use_next[rel_idx]           = 1'b0;
                                    written_next[IDX_W'(fc_reg)]   = 1'b1;
                                    fc_next                        = fc_reg + 1'b1;
                                    out_status_next                = ST_RELEASED;
                                    out_free_next                  = FREE_W'(fc_reg + 1'b1);
                                end
                                else
                                begin
                                    out_status_next = ST_IGNORED;
                                    out_free_next   = FREE_W'(fc_reg);
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Pop the top entry: read it and shrink the stack
                ram_re          = 1'b1;
                rd_written_next = written_reg[ram_raddr];
                rd_idx_next     = ram_raddr;
                fc_next         = fc_reg - 1'b1;
                state_next      = S_GRANT;
            end
            S_GRANT:
            begin
                if (out_room)
                begin
                    in_use_next[pop_handle] = 1'b1;
                    out_valid_next          = 1'b1;
                    out_status_next         = ST_GRANTED;
                    out_handle_next         = HANDLE_W'(pop_handle);
                    out_free_next           = FREE_W'(fc_reg);
                    out_last_next           = (rem_reg == COUNT_W'(1));
                    rem_next                = rem_reg - 1'b1;
                    state_next              = (rem_reg == COUNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pool_size_reg  <= POOL_SIZE_RST;
            fc_reg         <= CNT_W'(FC_RST);
            in_use_reg     <= '0;
            written_reg    <= '0;
            rem_reg        <= '0;
            rd_written_reg <= 1'b0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_handle_reg <= '0;
            out_free_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pool_size_reg  <= pool_size_next;
            fc_reg         <= fc_next;
            in_use_reg     <= in_use_next;
            written_reg    <= written_next;
            rem_reg        <= rem_next;
            rd_written_reg <= rd_written_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_handle_reg <= out_handle_next;
            out_free_reg   <= out_free_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_handle = out_handle_reg;
    assign rsp.free_left      = out_free_reg;
    assign rsp.last           = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/batch_handle_pool_allocator.sv
// Batch handle pool allocator: hands out numbered handles from a LIFO free stack.
// Channels:
//   cmd  - command transactions (action, count, handle), valid/ready.
//   rsp  - result transactions (status, granted_handle, free_left, last), valid/ready.
//   cfg  - cfg_we/cfg_wdata write pool_size; write only while the block is idle.
// An init command refills the pool and gives no result. A request gives either a
// burst of grants (last set on the final one) or one refusal/none result. A release
// gives one result. Unknown actions are dropped without a result.
// Path: a command crosses a 2-entry queue, then the back end; a single-result
// command's result is loaded into the back end's result register once it leaves the queue.
// Throughput: inits sustain one per cycle, and single-result commands do so while rsp.ready
// stays high. A request of n handles holds the back end for n passes of S_READ and S_GRANT:
// each pop is a read of the stack memory (registered read port) followed by the result load.
// Reset: pool_size is 32, the stack holds handles 0..POOL_MAX-1 in order with the
// first min(32, POOL_MAX) free, nothing is in use.
// Receiver stall: the result register holds; the back end waits, the queue fills,
// then cmd.ready drops.
`default_nettype none

module batch_handle_pool_allocator import bhpa_pkg::*; #(
    parameter int POOL_MAX = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bhpa_cmd_if.sink                    cmd,
    bhpa_rsp_if.source                  rsp,
    input  wire logic                   cfg_we,
    input  wire logic [POOL_SIZE_W-1:0] cfg_wdata
);

    logic push_valid;
    cmd_t push_cmd;
    logic push_ready;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Front end: decode and accept
    bhpa_front u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Command queue
    bhpa_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop)
    );

    // Back end: stack, bitmap and result register
    bhpa_back #(
        .POOL_MAX (POOL_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .rsp       (rsp)
    );

    // Non-grant results are single and carry no handle
    a_nongrant_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_GRANTED) |-> rsp.last && (rsp.granted_handle == '0))
        else $error("non-grant result without last or with a handle");

    // Free count never exceeds the pool
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (32'(rsp.free_left) <= POOL_MAX))
        else $error("free_left above pool capacity");

    // A stalled result holds still until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready
        |=> rsp.valid && $stable({rsp.status, rsp.granted_handle, rsp.free_left, rsp.last}))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
